### rtl/core/fba_pkg.sv
package fba_pkg;

    // Port field widths
    localparam int BLK_W  = 5;
    localparam int SZ_W   = 16;
    localparam int CNT_W  = 6;
    localparam int POL_W  = 2;
    localparam int CFGI_W = 1;
    localparam int CFGD_W = 6;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Fit policy codes; the unused code behaves as first fit
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_FIT_POLICY  = 1'd0;
    localparam logic [CFGI_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    // Microprogram step addresses
    typedef logic [1:0] upc_t;
    localparam upc_t UPC_IDLE = 2'd0;
    localparam upc_t UPC_INIT = 2'd1;
    localparam upc_t UPC_SCAN = 2'd2;
    localparam upc_t UPC_UPD  = 2'd3;

    // Jump conditions
    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_ALLOC,
        JC_EMPTY,
        JC_SCAN_END,
        JC_OUT_FREE
    } jcond_t;

    // One control word
    typedef struct packed {
        logic   accept_en;
        logic   scan_clr;
        logic   scan_run;
        logic   emit;
        jcond_t cond;
        upc_t   target;
        logic   adv;
    } ucw_t;

    // Microprogram store
    function automatic ucw_t ucode_rom(input upc_t addr);
        ucw_t w;
        w = '0;
        case (addr)
            UPC_IDLE:
            begin
                w.accept_en = 1'b1;
                w.cond      = JC_ALLOC;
                w.target    = UPC_INIT;
            end
            UPC_INIT:
            begin
                w.scan_clr  = 1'b1;
                w.cond      = JC_EMPTY;
                w.target    = UPC_UPD;
                w.adv       = 1'b1;
            end
            UPC_SCAN:
            begin
                w.scan_run  = 1'b1;
                w.cond      = JC_SCAN_END;
                w.target    = UPC_UPD;
            end
            UPC_UPD:
            begin
                w.emit      = 1'b1;
                w.cond      = JC_OUT_FREE;
                w.target    = UPC_IDLE;
            end
            default:
            begin
                w.cond      = JC_ALWAYS;
                w.target    = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/core/fit_policy_block_allocator_unit.sv
// Load: written to the table on transfer, accepted back to back.
// Allocate: accept, one init step, one scan step per block scanned, one update step;
// first fit ends at the first fitting block.
// The single free-space table read port sets the one-block-per-cycle scan.
// The result waits in an output register; the next item is taken while it waits.
// rst_n clears control and configuration; the free-space table is undefined until loaded.
module fit_policy_block_allocator_unit #(
    parameter int MAX_BLOCKS = 32,
    parameter int SIZE_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [fba_pkg::CFGI_W-1:0]  cfg_index,
    input  logic [fba_pkg::CFGD_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [fba_pkg::BLK_W-1:0]   block_index,
    input  logic [fba_pkg::SZ_W-1:0]    size_value,
    input  logic                        last_request,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        granted,
    output logic [fba_pkg::BLK_W-1:0]   chosen_block,
    output logic [fba_pkg::SZ_W-1:0]    free_before,
    output logic [fba_pkg::SZ_W-1:0]    leftover,
    output logic                        batch_end
);

    import fba_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(MAX_BLOCKS - 1);

    // Configuration
    logic [POL_W-1:0] policy_reg;
    logic [CNT_W-1:0] count_reg;

    // Sequencer and datapath registers
    upc_t             upc_reg, upc_next;
    ucw_t             uw;
    logic             found_reg;
    logic [IDX_W-1:0] scan_reg;
    logic [IDX_W-1:0] last_reg;
    logic [IDX_W-1:0] pick_reg;
    logic [SIZE_BITS-1:0] best_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic             batch_reg;

    // Output slot
    logic             out_valid_reg;
    logic             granted_reg;
    logic [BLK_W-1:0] chosen_reg;
    logic [SZ_W-1:0]  before_reg;
    logic [SZ_W-1:0]  left_reg;
    logic             bend_reg;

    // Table port
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    logic in_xfer, alloc_xfer, load_ok, out_free;
    logic count_empty, count_sat;
    logic fits, take_first, better, first_fit, scan_end, cond_true, commit;
    logic [SIZE_BITS-1:0] req_in, diff;

    assign uw = ucode_rom(upc_reg);

    assign in_ready   = uw.accept_en;
    assign in_xfer    = in_valid && in_ready;
    assign alloc_xfer = in_xfer && (command == CMD_ALLOC);
    assign load_ok    = 32'(block_index) < 32'(MAX_BLOCKS);
    assign req_in     = SIZE_BITS'(size_value);
    assign out_free   = !out_valid_reg || out_ready;

    assign count_empty = (count_reg == '0);
    assign count_sat   = 32'(count_reg) > 32'(MAX_BLOCKS);

    // Evaluate the entry read back for the current scan index
    assign fits       = ram_rdata >= req_reg;
    assign first_fit  = (policy_reg != POL_BEST) && (policy_reg != POL_WORST);
    assign take_first = fits && !found_reg;
    assign better     = fits && found_reg &&
                        (((policy_reg == POL_BEST) && (ram_rdata < best_reg)) ||
                         ((policy_reg == POL_WORST) && (ram_rdata > best_reg)));
    assign scan_end   = (scan_reg == last_reg) || (take_first && first_fit);
    assign diff       = best_reg - req_reg;
    assign commit     = uw.emit && out_free;

    // Resolve the jump condition
    always_comb
    begin
        case (uw.cond)
            JC_ALWAYS:   cond_true = 1'b1;
            JC_ALLOC:    cond_true = alloc_xfer;
            JC_EMPTY:    cond_true = count_empty;
            JC_SCAN_END: cond_true = scan_end;
            JC_OUT_FREE: cond_true = out_free;
            default:     cond_true = 1'b1;
        endcase
        if (cond_true)
        begin
            upc_next = uw.target;
        end
        else if (uw.adv)
        begin
            upc_next = upc_reg + upc_t'(1);
        end
        else
        begin
            upc_next = upc_reg;
        end
    end

    // Table write: a load on transfer, or the reduced size on commit
    always_comb
    begin
        if (uw.emit)
        begin
            ram_we    = commit && found_reg;
            ram_waddr = pick_reg;
            ram_wdata = diff;
        end
        else
        begin
            ram_we    = in_xfer && (command == CMD_LOAD) && load_ok;
            ram_waddr = IDX_W'(block_index);
            ram_wdata = req_in;
        end
    end

    // Prefetch the next scan entry
    assign ram_raddr = uw.scan_clr ? '0 : scan_reg + IDX_W'(1);

    fba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UPC_IDLE;
            policy_reg    <= POL_FIRST;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (cfg_write && (cfg_index == CFG_FIT_POLICY))
            begin
                policy_reg <= POL_W'(cfg_data);
            end
            if (cfg_write && (cfg_index == CFG_BLOCK_COUNT))
            begin
                count_reg <= CNT_W'(cfg_data);
            end
            if (uw.scan_clr)
            begin
                found_reg <= 1'b0;
            end
            else if (uw.scan_run && fits)
            begin
                found_reg <= 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (alloc_xfer)
        begin
            req_reg   <= req_in;
            batch_reg <= last_request;
        end
        if (uw.scan_clr)
        begin
            scan_reg <= '0;
            last_reg <= count_sat ? LAST_MAX : IDX_W'(count_reg - CNT_W'(1));
        end
        else if (uw.scan_run)
        begin
            scan_reg <= scan_reg + IDX_W'(1);
        end
        if (uw.scan_run && (take_first || better))
        begin
            pick_reg <= scan_reg;
            best_reg <= ram_rdata;
        end
        if (commit)
        begin
            granted_reg <= found_reg;
            chosen_reg  <= found_reg ? BLK_W'(pick_reg) : '0;
            before_reg  <= found_reg ? SZ_W'(best_reg) : '0;
            left_reg    <= found_reg ? SZ_W'(diff) : '0;
            bend_reg    <= batch_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted      = granted_reg;
    assign chosen_block = chosen_reg;
    assign free_before  = before_reg;
    assign leftover     = left_reg;
    assign batch_end    = bend_reg;

    // Allocate transfer starts the scan program
    a_alloc_init: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_xfer |=> (upc_reg == UPC_INIT))
        else $error("allocate transfer did not start scan");

    // Scan index never passes the last block in use
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UPC_SCAN) |-> (scan_reg <= last_reg))
        else $error("scan index out of range");

    // Update step holds while the output slot is occupied
    a_upd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((upc_reg == UPC_UPD) && out_valid_reg && !out_ready) |=> (upc_reg == UPC_UPD))
        else $error("result overwrote a pending transfer");

    // A refused request reports zero fields
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !granted) |->
            ((chosen_block == '0) && (free_before == '0) && (leftover == '0)))
        else $error("refused request with nonzero fields");

endmodule

### rtl/core/fba_ram.sv
module fba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### tb/tb_fit_policy_block_allocator_unit.sv
module tb_fit_policy_block_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fba_pkg::*;

    // The spare policy code, expected to act as first fit
    localparam logic [POL_W-1:0] POL_SPARE = 2'd3;
    localparam int NUM_BLOCKS   = 32;
    localparam int TOTAL_CMDS   = 1150;
    localparam int SETTLE_CYC   = 40;
    localparam int HOLD_CYC     = 400;
    localparam int QUIET_LIMIT  = 3000;

    typedef struct packed {
        logic             granted;
        logic [BLK_W-1:0] chosen_block;
        logic [SZ_W-1:0]  free_before;
        logic [SZ_W-1:0]  leftover;
        logic             batch_end;
    } grant_rec_t;

    // Free-space table mirror, predicted grants, and their comparison
    class fit_tracker;
        logic [SZ_W-1:0]  free_tbl [NUM_BLOCKS];
        logic [POL_W-1:0] policy;
        logic [CNT_W-1:0] count;
        grant_rec_t       grants_due [$];
        int               errors;
        int               results;
        int               grants;
        int               settings;

        function new();
            foreach (free_tbl[i])
                free_tbl[i] = '0;
            policy   = POL_FIRST;
            count    = '0;
            errors   = 0;
            results  = 0;
            grants   = 0;
            settings = 0;
        endfunction

        function void set_reg(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] data);
            if (idx == CFG_FIT_POLICY)
                policy = data[POL_W-1:0];
            else
                count = data[CNT_W-1:0];
            settings++;
        endfunction

        function int blocks_in_use();
            return (count > NUM_BLOCKS) ? NUM_BLOCKS : int'(count);
        endfunction

        // Note an accepted command; allocations queue their predicted grant
        function void apply_command(logic cmd, logic [BLK_W-1:0] idx,
                                    logic [SZ_W-1:0] sz, logic last);
            grant_rec_t g;
            int         n;
            int         pick;
            bit         found;
            if (cmd == CMD_LOAD)
            begin
                free_tbl[idx] = sz;
                return;
            end
            n     = blocks_in_use();
            pick  = 0;
            found = 1'b0;
            for (int j = 0; j < n; j++)
            begin
                if (free_tbl[j] < sz)
                    continue;
                if (!found)
                begin
                    found = 1'b1;
                    pick  = j;
                    if (policy != POL_BEST && policy != POL_WORST)
                        break;
                end
                else if (policy == POL_BEST && free_tbl[j] < free_tbl[pick])
                    pick = j;
                else if (policy == POL_WORST && free_tbl[j] > free_tbl[pick])
                    pick = j;
            end
            g = '0;
            g.batch_end = last;
            if (found)
            begin
                g.granted      = 1'b1;
                g.chosen_block = BLK_W'(pick);
                g.free_before  = free_tbl[pick];
                g.leftover     = free_tbl[pick] - sz;
                free_tbl[pick] = g.leftover;
            end
            grants_due.push_back(g);
        endfunction

        // Compare a result transfer against the oldest predicted grant
        function void check_grant(grant_rec_t got);
            grant_rec_t want;
            if (grants_due.size() == 0)
            begin
                $error("result with nothing outstanding: granted %0d block %0d",
                       got.granted, got.chosen_block);
                errors++;
                return;
            end
            want = grants_due.pop_front();
            results++;
            if (got.granted)
                grants++;
            if (got.granted !== want.granted)
            begin
                $error("granted: expected %0d, actual %0d", want.granted, got.granted);
                errors++;
            end
            if (got.chosen_block !== want.chosen_block)
            begin
                $error("chosen_block: expected %0d, actual %0d",
                       want.chosen_block, got.chosen_block);
                errors++;
            end
            if (got.free_before !== want.free_before)
            begin
                $error("free_before: expected %0d, actual %0d",
                       want.free_before, got.free_before);
                errors++;
            end
            if (got.leftover !== want.leftover)
            begin
                $error("leftover: expected %0d, actual %0d", want.leftover, got.leftover);
                errors++;
            end
            if (got.batch_end !== want.batch_end)
            begin
                $error("batch_end: expected %0d, actual %0d", want.batch_end, got.batch_end);
                errors++;
            end
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_write    = 1'b0;
    logic [CFGI_W-1:0] cfg_index    = '0;
    logic [CFGD_W-1:0] cfg_data     = '0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              command      = CMD_LOAD;
    logic [BLK_W-1:0]  block_index  = '0;
    logic [SZ_W-1:0]   size_value   = '0;
    logic              last_request = 1'b0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic              granted;
    logic [BLK_W-1:0]  chosen_block;
    logic [SZ_W-1:0]   free_before;
    logic [SZ_W-1:0]   leftover;
    logic              batch_end;

    fit_tracker tracker = new();
    int  cmds_sent     = 0;
    int  send_idle_pct = 34;
    int  recv_idle_pct = 58;
    int  batch_left    = 3;
    int  quiet_cycles  = 0;
    bit  hold_rx       = 1'b0;
    bit  hold_done     = 1'b0;

    fit_policy_block_allocator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .block_index  (block_index),
        .size_value   (size_value),
        .last_request (last_request),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted      (granted),
        .chosen_block (chosen_block),
        .free_before  (free_before),
        .leftover     (leftover),
        .batch_end    (batch_end)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_grant('{granted, chosen_block, free_before, leftover, batch_end});
    end

    // Count cycles without any transfer or register write
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("fit_policy_block_allocator_unit: mismatch");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYC; c++)
                    @(posedge clk);
                hold_rx   = 1'b0;
                hold_done = 1'b1;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one command and hold it until the transfer
    task automatic send_cmd(input logic cmd, input logic [BLK_W-1:0] idx,
                            input logic [SZ_W-1:0] sz, input logic last);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        block_index  <= idx;
        size_value   <= sz;
        last_request <= last;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.apply_command(cmd, idx, sz, last);
        cmds_sent++;
        // swap idling sides after a third, then run without idling
        if (cmds_sent < TOTAL_CMDS / 3)
        begin
            send_idle_pct = 34;
            recv_idle_pct = 58;
        end
        else if (cmds_sent < 2 * TOTAL_CMDS / 3)
        begin
            send_idle_pct = 58;
            recv_idle_pct = 34;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (cmds_sent == 2 * TOTAL_CMDS / 3 + 80 && !hold_done)
            hold_rx = 1'b1;
    endtask

    // Drop valid and wait until all grants are back and the unit is quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.grants_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write both registers on back-to-back cycles
    task automatic write_config(input logic [POL_W-1:0] pol, input logic [CNT_W-1:0] cnt);
        logic [CFGD_W-1:0] pol_data;
        pol_data = {(CFGD_W-POL_W)'($urandom_range(0, 15)), pol};
        cfg_write <= 1'b1;
        cfg_index <= CFG_FIT_POLICY;
        cfg_data  <= pol_data;
        @(posedge clk);
        tracker.set_reg(CFG_FIT_POLICY, pol_data);
        cfg_index <= CFG_BLOCK_COUNT;
        cfg_data  <= CFGD_W'(cnt);
        @(posedge clk);
        tracker.set_reg(CFG_BLOCK_COUNT, CFGD_W'(cnt));
        cfg_write <= 1'b0;
    endtask

    function automatic logic [SZ_W-1:0] load_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
            return SZ_W'($urandom_range(0, 2000));
        return SZ_W'($urandom);
    endfunction

    // Allocation sizes: mostly drawn below some block's free space so grants happen
    function automatic logic [SZ_W-1:0] request_size();
        int r;
        int n;
        int j;
        r = $urandom_range(0, 99);
        n = tracker.blocks_in_use();
        if (r < 8)
            return '0;
        if (r < 16)
            return SZ_W'($urandom);
        if (r < 21)
            return '1;
        if (n == 0)
            return SZ_W'($urandom_range(0, 4000));
        j = $urandom_range(0, n - 1);
        return SZ_W'($urandom_range(0, int'(tracker.free_tbl[j])));
    endfunction

    // One random command: mostly allocations in batches, some reloads
    task automatic send_random();
        logic last;
        if ($urandom_range(0, 99) < 25)
            send_cmd(CMD_LOAD, BLK_W'($urandom_range(0, NUM_BLOCKS - 1)), load_size(),
                     logic'($urandom_range(0, 1)));
        else
        begin
            batch_left--;
            last = (batch_left == 0);
            if (last)
                batch_left = $urandom_range(1, 8);
            send_cmd(CMD_ALLOC, BLK_W'($urandom), request_size(), last);
        end
    endtask

    initial
    begin
        logic [POL_W-1:0] pol;
        logic [CNT_W-1:0] cnt;
        int               phase;
        int               span;
        int               cnt_plan [6];

        cnt_plan = '{32, 1, 63, 0, 33, 31};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Count zero after reset: nothing can be granted
        send_cmd(CMD_ALLOC, 5'd31, 16'd0, 1'b1);
        send_cmd(CMD_ALLOC, 5'd0, 16'hFFFF, 1'b0);
        // Load the first blocks; the end-of-batch flag on a load has no effect
        send_cmd(CMD_LOAD, 5'd0, 16'hFFFF, 1'b1);
        send_cmd(CMD_LOAD, 5'd1, 16'd0, 1'b0);
        send_cmd(CMD_LOAD, 5'd2, 16'd100, 1'b0);
        send_cmd(CMD_LOAD, 5'd3, 16'd300, 1'b1);
        send_cmd(CMD_LOAD, 5'd4, 16'd100, 1'b0);
        drain();
        write_config(POL_FIRST, 6'd5);
        send_cmd(CMD_ALLOC, 5'd0, 16'd50, 1'b0);
        send_cmd(CMD_ALLOC, 5'd0, 16'd0, 1'b0);
        send_cmd(CMD_ALLOC, 5'd0, 16'hFFFF, 1'b1);
        drain();
        // Best fit with a tie between equal blocks
        write_config(POL_BEST, 6'd5);
        send_cmd(CMD_ALLOC, 5'd0, 16'd100, 1'b0);
        send_cmd(CMD_ALLOC, 5'd0, 16'd100, 1'b0);
        send_cmd(CMD_ALLOC, 5'd0, 16'd1, 1'b1);
        drain();
        write_config(POL_WORST, 6'd5);
        send_cmd(CMD_ALLOC, 5'd0, 16'd1, 1'b0);
        send_cmd(CMD_ALLOC, 5'd0, 16'd0, 1'b1);
        drain();
        write_config(POL_SPARE, 6'd5);
        send_cmd(CMD_ALLOC, 5'd0, 16'd10, 1'b1);

        // Fill the whole table before any larger count is used
        for (int b = 0; b < NUM_BLOCKS; b++)
            send_cmd(CMD_LOAD, BLK_W'(b), load_size(), 1'b0);

        phase = 0;
        while (cmds_sent < TOTAL_CMDS)
        begin
            drain();
            pol = POL_W'(phase % 4);
            if (phase < 6)
                cnt = CNT_W'(cnt_plan[phase]);
            else if ($urandom_range(0, 3) == 0)
                cnt = CNT_W'($urandom_range(0, 63));
            else
                cnt = CNT_W'($urandom_range(2, 32));
            write_config(pol, cnt);
            span = $urandom_range(30, 70);
            for (int k = 0; k < span; k++)
                send_random();
            phase++;
        end
        drain();

        $display("covered %0d commands over %0d register writes",
                 cmds_sent, tracker.settings);
        $display("%0d allocation results, %0d granted; %s",
                 tracker.results, tracker.grants,
                 "all four policy codes, counts 0 to 63, one long result hold-off");
        if (tracker.errors == 0 && tracker.grants_due.size() == 0)
            $display("fit_policy_block_allocator_unit: match");
        else
            $display("fit_policy_block_allocator_unit: mismatch");
        $finish;
    end

endmodule
